// ===== rtl/memory_map_to_sparse_chunks_defines.svh =====
// Assertion macros shared by the sparse chunk list RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef MEMORY_MAP_TO_SPARSE_CHUNKS_DEFINES_SVH
`define MEMORY_MAP_TO_SPARSE_CHUNKS_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MMSC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mmsc_pkg.sv =====
// Shared types, widths and codes for the sparse chunk list builder.
// No dependencies; imported by every module of the block.
package mmsc_pkg;

   localparam int START_W   = 40;
   localparam int PAGES_W   = 24;
   localparam int PAGE_W    = START_W + 1;
   localparam int BLOCKS_W  = 32;
   localparam int BLK_W     = 48;
   localparam int BYTE_W    = 56;
   localparam int ALU_W     = BYTE_W;
   localparam int STATUS_W  = 3;
   localparam int KIND_W    = 2;

   localparam int MAX_CHUNKS = 256;
   localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);

   localparam int PAGE_BYTES      = 4096;
   localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);
   localparam int CHUNK_HDR_BYTES = 12;
   localparam int FILE_HDR_BYTES  = 28;
   localparam logic [BLOCKS_W-1:0] PIECE_PAGES =
      BLOCKS_W'((64'd4294967296 - 64'(PAGE_BYTES)) / 64'(PAGE_BYTES));

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_END   = 1'b1;

   // Record kinds
   localparam logic [KIND_W-1:0] KIND_CHUNK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STS_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] STS_OVERLAP       = 3'd1;
   localparam logic [STATUS_W-1:0] STS_TOO_MANY      = 3'd2;
   localparam logic [STATUS_W-1:0] STS_HOLE_BIG      = 3'd3;
   localparam logic [STATUS_W-1:0] STS_END_UNREACH   = 3'd4;
   localparam logic [STATUS_W-1:0] STS_START_UNREACH = 3'd5;

   typedef struct packed {
      logic [START_W-1:0] start_page;
      logic [PAGES_W-1:0] pages;
      logic               usable;
      logic               last;
   } item_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic                raw;
      logic [BLOCKS_W-1:0] blocks;
      logic [BLOCKS_W-1:0] total_bytes;
      logic [CNT_W-1:0]    chunk_count;
      logic [BLK_W-1:0]    block_count;
      logic [BYTE_W-1:0]   image_bytes;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rec_type;

endpackage

// ===== rtl/mmsc_alu.sv =====
// Shared add/subtract unit of the sparse chunk list builder.
// Depends on mmsc_pkg for the datapath width.
module mmsc_alu import mmsc_pkg::*; (
   input  logic [ALU_W-1:0] alu_a,
   input  logic [ALU_W-1:0] alu_b,
   input  logic             alu_sub,
   output logic [ALU_W-1:0] alu_sum,
   output logic             alu_carry
);

   logic [ALU_W:0] full;
   logic [ALU_W-1:0] b_op;

   // Subtract as a + ~b + 1; carry out set means a >= b
   assign b_op = alu_sub ? ~alu_b : alu_b;
   assign full = {1'b0, alu_a} + {1'b0, b_op} + (ALU_W + 1)'(alu_sub);
   assign alu_sum   = full[ALU_W-1:0];
   assign alu_carry = full[ALU_W];

endmodule

// ===== rtl/mmsc_ctrl.sv =====
// Sequencer of the sparse chunk list builder: clips, splits, counts, reports.
// Depends on mmsc_pkg, mmsc_alu and the assertion macro header.
`include "memory_map_to_sparse_chunks_defines.svh"

module mmsc_ctrl import mmsc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  item_type           req_item,
   input  logic [START_W-1:0] win_start,
   input  logic [START_W-1:0] win_end,
   input  logic               out_free,
   output logic               push,
   output rec_type            push_rec
);

   typedef enum logic [4:0] {
      S_IDLE, S_END, S_WS, S_PREV, S_HLO, S_HHI, S_HLEN, S_HCHK, S_HEND,
      S_RLO, S_RHI, S_RLEN, S_SPLIT, S_SUBP, S_RDONE, S_ADD, S_ABLK,
      S_ABYTE, S_PUT, S_LAST, S_SUM, S_CLEAR, S_FLUSH
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [PAGE_W-1:0] tail_page_ff, tail_page_in;
   logic [CNT_W-1:0]  chunk_cnt_ff, chunk_cnt_in;
   logic [BLK_W-1:0]  blk_tot_ff, blk_tot_in;
   logic [BYTE_W-1:0] byte_tot_ff, byte_tot_in;
   logic              reached_ff, reached_in;
   logic              stopped_ff, stopped_in;
   logic              pend_valid_ff, pend_valid_in;

   item_type          item_ff, item_in;
   logic [PAGE_W-1:0] end_ff, end_in;
   logic [PAGE_W-1:0] lo_ff, lo_in;
   logic [PAGE_W-1:0] hi_ff, hi_in;
   logic [PAGE_W-1:0] len_ff, len_in;
   logic              we_lt_ff, we_lt_in;
   logic              re_ff, re_in;
   rec_type           nrec_ff, nrec_in;
   rec_type           pend_ff, pend_in;

   logic [ALU_W-1:0]  alu_a, alu_b, alu_sum;
   logic              alu_sub, alu_carry, alu_zero, we_nz, lt;

   function automatic rec_type chunk_rec(input logic raw, input logic [BLOCKS_W-1:0] blocks);
      rec_type r;
      r = '0;
      r.kind   = KIND_CHUNK;
      r.raw    = raw;
      r.blocks = blocks;
      r.total_bytes = raw ? ((blocks << PAGE_SHIFT) | BLOCKS_W'(CHUNK_HDR_BYTES))
                          : BLOCKS_W'(CHUNK_HDR_BYTES);
      return r;
   endfunction

   function automatic rec_type err_rec(input logic [STATUS_W-1:0] sts);
      rec_type r;
      r = '0;
      r.kind   = KIND_ERROR;
      r.status = sts;
      return r;
   endfunction

   mmsc_alu u_alu (
      .alu_a     (alu_a),
      .alu_b     (alu_b),
      .alu_sub   (alu_sub),
      .alu_sum   (alu_sum),
      .alu_carry (alu_carry)
   );

   assign alu_zero  = (alu_sum == '0);
   assign we_nz     = (win_end != '0);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      tail_page_in  = tail_page_ff;
      chunk_cnt_in  = chunk_cnt_ff;
      blk_tot_in    = blk_tot_ff;
      byte_tot_in   = byte_tot_ff;
      reached_in    = reached_ff;
      stopped_in    = stopped_ff;
      pend_valid_in = pend_valid_ff;
      item_in       = item_ff;
      end_in        = end_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      len_in        = len_ff;
      we_lt_in      = we_lt_ff;
      re_in         = re_ff;
      nrec_in       = nrec_ff;
      pend_in       = pend_ff;
      alu_a         = '0;
      alu_b         = '0;
      alu_sub       = 1'b0;
      lt            = 1'b0;
      push          = 1'b0;
      push_rec      = pend_ff;
      push_rec.last = (state_ff == S_FLUSH);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_item;
               state_in = (stopped_ff || reached_ff) ? S_LAST : S_END;
            end
         end
         S_END: begin
            alu_a    = ALU_W'(item_ff.start_page);
            alu_b    = ALU_W'(item_ff.pages);
            end_in   = alu_sum[PAGE_W-1:0];
            state_in = S_WS;
         end
         S_WS: begin
            alu_a   = ALU_W'(win_start);
            alu_b   = ALU_W'(end_ff);
            alu_sub = 1'b1;
            if (alu_carry) begin
               // Region wholly below the window: move the end mark only
               tail_page_in = end_ff;
               state_in     = S_LAST;
            end else begin
               state_in = S_PREV;
            end
         end
         S_PREV: begin
            alu_a   = ALU_W'(item_ff.start_page);
            alu_b   = ALU_W'(tail_page_ff);
            alu_sub = 1'b1;
            if (!alu_carry) begin
               nrec_in    = err_rec(STS_OVERLAP);
               stopped_in = 1'b1;
               ret_in     = S_LAST;
               state_in   = S_PUT;
            end else if (alu_zero) begin
               state_in = S_RLO;
            end else begin
               state_in = S_HLO;
            end
         end
         S_HLO: begin
            alu_a    = ALU_W'(tail_page_ff);
            alu_b    = ALU_W'(win_start);
            alu_sub  = 1'b1;
            lo_in    = alu_carry ? tail_page_ff : PAGE_W'(win_start);
            state_in = S_HHI;
         end
         S_HHI: begin
            alu_a    = ALU_W'(win_end);
            alu_b    = ALU_W'(item_ff.start_page);
            alu_sub  = 1'b1;
            lt       = we_nz && !alu_carry;
            we_lt_in = lt;
            hi_in    = lt ? PAGE_W'(win_end) : PAGE_W'(item_ff.start_page);
            state_in = S_HLEN;
         end
         S_HLEN: begin
            alu_a    = ALU_W'(hi_ff);
            alu_b    = ALU_W'(lo_ff);
            alu_sub  = 1'b1;
            len_in   = alu_carry ? alu_sum[PAGE_W-1:0] : '0;
            state_in = S_HCHK;
         end
         S_HCHK: begin
            if (len_ff[PAGE_W-1:BLOCKS_W] != '0) begin
               nrec_in    = err_rec(STS_HOLE_BIG);
               stopped_in = 1'b1;
               ret_in     = S_LAST;
               state_in   = S_PUT;
            end else if (len_ff != '0) begin
               nrec_in  = chunk_rec(1'b0, len_ff[BLOCKS_W-1:0]);
               ret_in   = S_HEND;
               state_in = S_ADD;
            end else begin
               state_in = S_HEND;
            end
         end
         S_HEND: begin
            if (we_lt_ff) begin
               reached_in = 1'b1;
               state_in   = S_LAST;
            end else begin
               state_in = S_RLO;
            end
         end
         S_RLO: begin
            alu_a    = ALU_W'(item_ff.start_page);
            alu_b    = ALU_W'(win_start);
            alu_sub  = 1'b1;
            lo_in    = alu_carry ? PAGE_W'(item_ff.start_page) : PAGE_W'(win_start);
            state_in = S_RHI;
         end
         S_RHI: begin
            alu_a    = ALU_W'(win_end);
            alu_b    = ALU_W'(end_ff);
            alu_sub  = 1'b1;
            lt       = we_nz && !alu_carry;
            hi_in    = lt ? PAGE_W'(win_end) : end_ff;
            re_in    = we_nz && (!alu_carry || alu_zero);
            state_in = S_RLEN;
         end
         S_RLEN: begin
            alu_a    = ALU_W'(hi_ff);
            alu_b    = ALU_W'(lo_ff);
            alu_sub  = 1'b1;
            len_in   = alu_carry ? alu_sum[PAGE_W-1:0] : '0;
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            if (item_ff.usable && (len_ff > PAGE_W'(PIECE_PAGES))) begin
               nrec_in  = chunk_rec(1'b1, PIECE_PAGES);
               ret_in   = S_SUBP;
               state_in = S_ADD;
            end else if (len_ff != '0) begin
               nrec_in  = chunk_rec(item_ff.usable, len_ff[BLOCKS_W-1:0]);
               ret_in   = S_RDONE;
               state_in = S_ADD;
            end else begin
               state_in = S_RDONE;
            end
         end
         S_SUBP: begin
            alu_a    = ALU_W'(len_ff);
            alu_b    = ALU_W'(PIECE_PAGES);
            alu_sub  = 1'b1;
            len_in   = alu_sum[PAGE_W-1:0];
            state_in = S_SPLIT;
         end
         S_RDONE: begin
            if (re_ff) begin
               reached_in = 1'b1;
            end
            tail_page_in = end_ff;
            state_in     = S_LAST;
         end
         S_ADD: begin
            if (chunk_cnt_ff >= CNT_W'(MAX_CHUNKS)) begin
               nrec_in    = err_rec(STS_TOO_MANY);
               stopped_in = 1'b1;
               ret_in     = S_LAST;
               state_in   = S_PUT;
            end else begin
               chunk_cnt_in = chunk_cnt_ff + CNT_W'(1);
               state_in     = S_ABLK;
            end
         end
         S_ABLK: begin
            alu_a      = ALU_W'(blk_tot_ff);
            alu_b      = ALU_W'(nrec_ff.blocks);
            blk_tot_in = alu_sum[BLK_W-1:0];
            state_in   = S_ABYTE;
         end
         S_ABYTE: begin
            alu_a       = ALU_W'(byte_tot_ff);
            alu_b       = ALU_W'(nrec_ff.total_bytes);
            byte_tot_in = alu_sum[BYTE_W-1:0];
            state_in    = S_PUT;
         end
         S_PUT: begin
            if (!pend_valid_ff || out_free) begin
               push          = pend_valid_ff;
               pend_in       = nrec_ff;
               pend_valid_in = 1'b1;
               state_in      = ret_ff;
            end
         end
         S_LAST: begin
            if (!item_ff.last) begin
               state_in = S_FLUSH;
            end else if (stopped_ff) begin
               state_in = S_CLEAR;
            end else if (we_nz && !reached_ff) begin
               nrec_in  = err_rec(STS_END_UNREACH);
               ret_in   = S_CLEAR;
               state_in = S_PUT;
            end else if (chunk_cnt_ff == '0) begin
               nrec_in  = err_rec(STS_START_UNREACH);
               ret_in   = S_CLEAR;
               state_in = S_PUT;
            end else begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            alu_a               = byte_tot_ff;
            alu_b               = ALU_W'(FILE_HDR_BYTES);
            nrec_in             = '0;
            nrec_in.kind        = KIND_SUMMARY;
            nrec_in.chunk_count = chunk_cnt_ff;
            nrec_in.block_count = blk_tot_ff;
            nrec_in.image_bytes = alu_sum[BYTE_W-1:0];
            ret_in              = S_CLEAR;
            state_in            = S_PUT;
         end
         S_CLEAR: begin
            tail_page_in = '0;
            chunk_cnt_in = '0;
            blk_tot_in   = '0;
            byte_tot_in  = '0;
            reached_in   = 1'b0;
            stopped_in   = 1'b0;
            state_in     = S_FLUSH;
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         tail_page_ff  <= '0;
         chunk_cnt_ff  <= '0;
         blk_tot_ff    <= '0;
         byte_tot_ff   <= '0;
         reached_ff    <= 1'b0;
         stopped_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         tail_page_ff  <= tail_page_in;
         chunk_cnt_ff  <= chunk_cnt_in;
         blk_tot_ff    <= blk_tot_in;
         byte_tot_ff   <= byte_tot_in;
         reached_ff    <= reached_in;
         stopped_ff    <= stopped_in;
         pend_valid_ff <= pend_valid_in;
      end
      item_ff  <= item_in;
      end_ff   <= end_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      len_ff   <= len_in;
      we_lt_ff <= we_lt_in;
      re_ff    <= re_in;
      nrec_ff  <= nrec_in;
      pend_ff  <= pend_in;
   end

   `MMSC_ASSERT_IMPL(a_push_needs_slot, push, out_free,
                     "word pushed into a full output slot")
   `MMSC_ASSERT_IMPL(a_cnt_bound, 1'b1, chunk_cnt_ff <= CNT_W'(MAX_CHUNKS),
                     "chunk count past limit")
   `MMSC_ASSERT_IMPL(a_idle_flushed, req_ready, !pend_valid_ff, "idle with a held word")
   `MMSC_ASSERT_IMPL(a_summary_last, push && (push_rec.kind == KIND_SUMMARY),
                     push_rec.last, "summary not last")
   `MMSC_ASSERT_NEXT(a_skip_when_done,
                     req_valid && req_ready && (stopped_ff || reached_ff),
                     state_ff == S_LAST, "stopped map still processed")

endmodule

// ===== rtl/memory_map_to_sparse_chunks.sv =====
// An item holds req_ready low while it is clipped, split into chunks and handed off, with
// up to 16 extra raw pieces when a usable region is split; each chunk goes through count,
// two sums and hand-off in turn.
// Throughput: one item at a time; the single shared 56-bit add/subtract unit sets the pace.
// Back-pressure on rsp holds the sequencer whenever a held word meets a full output slot.
// Reset (synchronous, active high) clears the window registers, totals and output slot.
module memory_map_to_sparse_chunks import mmsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // Region words in
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [START_W-1:0]   req_region_start_page,
   input  logic [PAGES_W-1:0]   req_region_pages,
   input  logic                 req_region_usable,
   input  logic                 req_last_region,
   // Chunk, summary and error words out
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KIND_W-1:0]    rsp_record_kind,
   output logic                 rsp_chunk_raw,
   output logic [BLOCKS_W-1:0]  rsp_chunk_blocks,
   output logic [BLOCKS_W-1:0]  rsp_chunk_total_bytes,
   output logic [CNT_W-1:0]     rsp_total_chunk_count,
   output logic [BLK_W-1:0]     rsp_total_block_count,
   output logic [BYTE_W-1:0]    rsp_image_bytes,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_last_result,
   // Window registers
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [START_W-1:0]   csr_write_data
);

   logic [START_W-1:0] win_start_ff, win_start_in;
   logic [START_W-1:0] win_end_ff, win_end_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rec_type            rsp_rec_ff, rsp_rec_in;
   item_type           req_item;
   logic               out_free;
   logic               push;
   rec_type            push_rec;

   // Pack the region word for the sequencer
   assign req_item.start_page = req_region_start_page;
   assign req_item.pages      = req_region_pages;
   assign req_item.usable     = req_region_usable;
   assign req_item.last       = req_last_region;

   // Window register decode; a write lands at once, so keep writes clear of a word in flight
   always_comb begin
      win_start_in = win_start_ff;
      win_end_in   = win_end_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WIN_START: win_start_in = csr_write_data;
            CSR_WIN_END:   win_end_in   = csr_write_data;
            default: begin
               win_start_in = win_start_ff;
            end
         endcase
      end
   end

   // Output slot: free when empty or being drained this cycle.
   // The sequencer keeps the newest word back so that it can flag the last one.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_rec_in   = rsp_rec_ff;
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_rec_in   = push_rec;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= '0;
         win_end_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_start_ff <= win_start_in;
         win_end_ff   <= win_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_rec_ff <= rsp_rec_in;
   end

   mmsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .win_start (win_start_ff),
      .win_end   (win_end_ff),
      .out_free  (out_free),
      .push      (push),
      .push_rec  (push_rec)
   );

   // Drive the result ports from the output slot
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_record_kind       = rsp_rec_ff.kind;
   assign rsp_chunk_raw         = rsp_rec_ff.raw;
   assign rsp_chunk_blocks      = rsp_rec_ff.blocks;
   assign rsp_chunk_total_bytes = rsp_rec_ff.total_bytes;
   assign rsp_total_chunk_count = rsp_rec_ff.chunk_count;
   assign rsp_total_block_count = rsp_rec_ff.block_count;
   assign rsp_image_bytes       = rsp_rec_ff.image_bytes;
   assign rsp_status            = rsp_rec_ff.status;
   assign rsp_last_result       = rsp_rec_ff.last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for memory_map_to_sparse_chunks: feeds memory-map regions, predicts
// every chunk, summary and error word and checks them in arrival order.
// Depends on mmsc_pkg and the block's RTL only.
module tb import mmsc_pkg::*; ();

   // Slowest correct run: about 200 region words, up to 20 result words each, every result
   // held off by a random stall and the adder taking each chunk's steps in turn, plus the drain
   // pauses between maps. The limit allows for that several times over.
   localparam int unsigned LIMIT_CYCLES = 600000;
   // Covers the longest internal run of a region, including its 16 extra raw pieces at most.
   localparam int DRAIN_CYCLES = 160;
   localparam int RANDOM_WORDS = 160;
   localparam logic [START_W-1:0] TOP_PAGE  = '1;
   localparam logic [PAGES_W-1:0] MAX_PAGES = '1;

   typedef enum {MAP_TIDY, MAP_OVERLAP, MAP_FAR, MAP_NOISE, MAP_CROWDED} map_style_type;

   // Shadow of the chunk list builder: window registers, running totals and the queue of
   // words that the block still owes us.
   class chunk_list_tracker_type;
      logic [START_W-1:0] win_start;
      logic [START_W-1:0] win_end;
      logic [PAGE_W-1:0]  tail_page;
      int unsigned        chunks;
      logic [BLK_W-1:0]   block_sum;
      logic [BYTE_W-1:0]  byte_sum;
      bit                 reached_end;
      bit                 halted;
      rec_type            pending_records[$];
      int unsigned        bad_records;

      function new();
         win_start   = '0;
         win_end     = '0;
         bad_records = 0;
         clear_map();
      endfunction

      function void clear_map();
         tail_page   = '0;
         chunks      = 0;
         block_sum   = '0;
         byte_sum    = '0;
         reached_end = 1'b0;
         halted      = 1'b0;
      endfunction

      function void write_window(logic [CSR_IDX_W-1:0] idx, logic [START_W-1:0] value);
         if (idx == CSR_WIN_START) begin
            win_start = value;
         end else begin
            win_end = value;
         end
      endfunction

      function void push_record(logic [KIND_W-1:0] kind, logic raw,
                                logic [BLOCKS_W-1:0] blocks, logic [BLOCKS_W-1:0] total,
                                logic [CNT_W-1:0] count, logic [BLK_W-1:0] blk,
                                logic [BYTE_W-1:0] img, logic [STATUS_W-1:0] status);
         rec_type w;
         w.kind        = kind;
         w.raw         = raw;
         w.blocks      = blocks;
         w.total_bytes = total;
         w.chunk_count = count;
         w.block_count = blk;
         w.image_bytes = img;
         w.status      = status;
         w.last        = 1'b0;
         pending_records.push_back(w);
      endfunction

      // Append one chunk unless the table is full.
      function logic [STATUS_W-1:0] add_chunk(bit raw, logic [63:0] pages);
         logic [63:0] bytes;
         if (chunks >= MAX_CHUNKS) return STS_TOO_MANY;
         bytes = 64'(CHUNK_HDR_BYTES);
         if (raw) bytes += pages << PAGE_SHIFT;
         chunks++;
         block_sum += BLK_W'(pages);
         byte_sum  += BYTE_W'(bytes);
         push_record(KIND_CHUNK, raw, pages[31:0], bytes[31:0], '0, '0, '0, STS_OK);
         return STS_OK;
      endfunction

      function void note_region(item_type r);
         logic [63:0]         ws, we, first_pg, stop_pg, lo, hi, len;
         logic [STATUS_W-1:0] st;
         bit                  past_window;
         int                  queued_n;
         rec_type             tail;
         queued_n    = pending_records.size();
         ws          = 64'(win_start);
         we          = 64'(win_end);
         first_pg    = 64'(r.start_page);
         stop_pg     = first_pg + 64'(r.pages);
         st          = STS_OK;
         past_window = 1'b0;
         if (!halted && !reached_end) begin
            if (ws >= stop_pg) begin
               // wholly below the window: move the cursor, skip the overlap check
               tail_page = PAGE_W'(stop_pg);
            end else if (64'(tail_page) > first_pg) begin
               st = STS_OVERLAP;
            end else begin
               if (64'(tail_page) != first_pg) begin
                  // don't-care hole since the previous region, clipped to the window
                  lo  = (64'(tail_page) > ws) ? 64'(tail_page) : ws;
                  hi  = (we != 0 && we < first_pg) ? we : first_pg;
                  len = (hi > lo) ? hi - lo : 64'd0;
                  if (len > 64'hFFFF_FFFF) begin
                     st = STS_HOLE_BIG;
                  end else if (len != 0) begin
                     st = add_chunk(1'b0, len);
                  end
                  if (st == STS_OK && we != 0 && we < first_pg) begin
                     reached_end = 1'b1;
                     past_window = 1'b1;
                  end
               end
               if (st == STS_OK && !past_window) begin
                  lo  = (first_pg > ws) ? first_pg : ws;
                  hi  = (we != 0 && we < stop_pg) ? we : stop_pg;
                  len = (hi > lo) ? hi - lo : 64'd0;
                  // split raw data that would not fit a 32-bit chunk size
                  if (r.usable) begin
                     while (st == STS_OK &&
                            (len << PAGE_SHIFT) + CHUNK_HDR_BYTES > 64'hFFFF_FFFF) begin
                        st  = add_chunk(1'b1, 64'(PIECE_PAGES));
                        len -= 64'(PIECE_PAGES);
                     end
                  end
                  if (st == STS_OK && len != 0) st = add_chunk(r.usable, len);
                  if (st == STS_OK) begin
                     if (we != 0 && we <= stop_pg) reached_end = 1'b1;
                     tail_page = PAGE_W'(stop_pg);
                  end
               end
            end
            if (st != STS_OK) begin
               halted = 1'b1;
               push_record(KIND_ERROR, 1'b0, '0, '0, '0, '0, '0, st);
            end
         end
         if (r.last) begin
            if (!halted) begin
               if (win_end != 0 && !reached_end) begin
                  push_record(KIND_ERROR, 1'b0, '0, '0, '0, '0, '0, STS_END_UNREACH);
               end else if (byte_sum == 0) begin
                  push_record(KIND_ERROR, 1'b0, '0, '0, '0, '0, '0, STS_START_UNREACH);
               end else begin
                  push_record(KIND_SUMMARY, 1'b0, '0, '0, CNT_W'(chunks), block_sum,
                              byte_sum + BYTE_W'(FILE_HDR_BYTES), STS_OK);
               end
            end
            clear_map();
         end
         // flag the final word of this region
         if (pending_records.size() > queued_n) begin
            tail      = pending_records.pop_back();
            tail.last = 1'b1;
            pending_records.push_back(tail);
         end
      endfunction

      function string show(rec_type x);
         return $sformatf({"kind=%0d raw=%0d blocks=%0d bytes=%0d count=%0d total_blocks=%0d",
                           " image=%0d status=%0d last=%0d"},
                          x.kind, x.raw, x.blocks, x.total_bytes, x.chunk_count,
                          x.block_count, x.image_bytes, x.status, x.last);
      endfunction

      function void check_record(rec_type got);
         rec_type want;
         string   diffs;
         if (pending_records.size() == 0) begin
            bad_records++;
            if (bad_records <= 10) $display("unexpected word: %s", show(got));
            return;
         end
         want  = pending_records.pop_front();
         diffs = "";
         if (got.kind        !== want.kind)        diffs = {diffs, " kind"};
         if (got.raw         !== want.raw)         diffs = {diffs, " raw"};
         if (got.blocks      !== want.blocks)      diffs = {diffs, " blocks"};
         if (got.total_bytes !== want.total_bytes) diffs = {diffs, " bytes"};
         if (got.chunk_count !== want.chunk_count) diffs = {diffs, " count"};
         if (got.block_count !== want.block_count) diffs = {diffs, " total_blocks"};
         if (got.image_bytes !== want.image_bytes) diffs = {diffs, " image"};
         if (got.status      !== want.status)      diffs = {diffs, " status"};
         if (got.last        !== want.last)        diffs = {diffs, " last"};
         if (diffs != "") begin
            bad_records++;
            if (bad_records <= 10) begin
               $display("mismatch in%s", diffs);
               $display("  expected %s", show(want));
               $display("  actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [START_W-1:0]   req_region_start_page;
   logic [PAGES_W-1:0]   req_region_pages;
   logic                 req_region_usable;
   logic                 req_last_region;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [KIND_W-1:0]    rsp_record_kind;
   logic                 rsp_chunk_raw;
   logic [BLOCKS_W-1:0]  rsp_chunk_blocks;
   logic [BLOCKS_W-1:0]  rsp_chunk_total_bytes;
   logic [CNT_W-1:0]     rsp_total_chunk_count;
   logic [BLK_W-1:0]     rsp_total_block_count;
   logic [BYTE_W-1:0]    rsp_image_bytes;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_last_result;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [START_W-1:0]   csr_write_data;

   chunk_list_tracker_type tracker = new();
   int unsigned            cycles = 0;
   int unsigned            words_sent = 0;
   bit                     calm = 1'b0;   // both sides run flat out while set

   memory_map_to_sparse_chunks dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_region_start_page (req_region_start_page),
      .req_region_pages      (req_region_pages),
      .req_region_usable     (req_region_usable),
      .req_last_region       (req_last_region),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_record_kind       (rsp_record_kind),
      .rsp_chunk_raw         (rsp_chunk_raw),
      .rsp_chunk_blocks      (rsp_chunk_blocks),
      .rsp_chunk_total_bytes (rsp_chunk_total_bytes),
      .rsp_total_chunk_count (rsp_total_chunk_count),
      .rsp_total_block_count (rsp_total_block_count),
      .rsp_image_bytes       (rsp_image_bytes),
      .rsp_status            (rsp_status),
      .rsp_last_result       (rsp_last_result),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always #1 clock = ~clock;

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [START_W-1:0] rand_page();
      return {8'($urandom_range(0, 255)), 32'($urandom())};
   endfunction

   // Offer one region word at a falling edge after a random gap; hold it until taken.
   // Entered and left at a falling edge.
   task automatic send_region(input logic [START_W-1:0] base, input logic [PAGES_W-1:0] len,
                              input bit usable, input bit closes);
      int       gap;
      item_type w;
      w.start_page = base;
      w.pages      = len;
      w.usable     = usable;
      w.last       = closes;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_region_start_page = base;
      req_region_pages      = len;
      req_region_usable     = usable;
      req_last_region       = closes;
      req_valid             = 1'b1;
      do @(posedge clock); while (!req_ready);
      tracker.note_region(w);
      words_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed word is in, then let the block drain
   // any trailing region that produces nothing.
   task automatic settle();
      req_valid = 1'b0;
      while (tracker.pending_records.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write both window registers while the block is idle.
   task automatic set_window(input logic [START_W-1:0] ws, input logic [START_W-1:0] we);
      settle();
      for (int i = 0; i < 2; i++) begin
         csr_write_enable = 1'b1;
         csr_index        = (i == 0) ? CSR_WIN_START : CSR_WIN_END;
         csr_write_data   = (i == 0) ? ws : we;
         @(posedge clock);
         tracker.write_window(csr_index, csr_write_data);
         @(negedge clock);
      end
      csr_write_enable = 1'b0;
   endtask

   // One memory map, closed by last_region. Tidy maps are sorted with small gaps to exercise
   // window clipping; overlap and far maps break one region on purpose, noise maps are random.
   task automatic run_map(input map_style_type style);
      int                 n, bad_at;
      logic [PAGE_W-1:0]  cursor;
      logic [START_W-1:0] base;
      logic [PAGES_W-1:0] len;
      bit                 usable, closes;
      n      = (style == MAP_CROWDED) ? 16 : $urandom_range(1, 8);
      bad_at = $urandom_range(0, n - 1);
      cursor = PAGE_W'($urandom_range(0, 40));
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0:       len = MAX_PAGES;
            1:       len = PAGES_W'($urandom());
            2:       len = '0;
            default: len = PAGES_W'($urandom_range(1, 60));
         endcase
         base = START_W'(cursor);
         if ($urandom_range(0, 1)) base += START_W'($urandom_range(1, 50));
         usable = $urandom_range(0, 1);
         closes = (k == n - 1);
         case (style)
            MAP_OVERLAP: begin
               // step back into the previous region
               if (k == bad_at && cursor != 0)
                  base = START_W'(cursor - 1 - ($urandom_range(0, 20) % cursor));
            end
            MAP_FAR: begin
               // leave a hole wider than a 32-bit block count
               if (k == bad_at) base += {8'($urandom_range(1, 255)), 32'($urandom())};
            end
            MAP_NOISE: begin
               base = rand_page();
               len  = PAGES_W'($urandom());
               if ($urandom_range(0, 3) == 0) closes = 1'b1;
            end
            MAP_CROWDED: begin
               // 17 chunks a region overflow the chunk table well before the end
               len    = MAX_PAGES;
               usable = 1'b1;
            end
            default: ;
         endcase
         send_region(base, len, usable, closes);
         cursor = PAGE_W'(base) + PAGE_W'(len);
      end
   endtask

   // Result side: stall at random, take one word per handshake and check it.
   initial begin
      rec_type got;
      int      stall;
      rsp_ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.kind        = rsp_record_kind;
         got.raw         = rsp_chunk_raw;
         got.blocks      = rsp_chunk_blocks;
         got.total_bytes = rsp_chunk_total_bytes;
         got.chunk_count = rsp_total_chunk_count;
         got.block_count = rsp_total_block_count;
         got.image_bytes = rsp_image_bytes;
         got.status      = rsp_status;
         got.last        = rsp_last_result;
         tracker.check_record(got);
         @(negedge clock);
      end
   end

   // Stimulus
   initial begin
      int                 goal, maps, pick;
      logic [START_W-1:0] ws, we;
      map_style_type      style;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_region_start_page = '0;
      req_region_pages      = '0;
      req_region_usable     = 1'b0;
      req_last_region       = 1'b0;
      csr_write_enable      = 1'b0;
      csr_index             = CSR_WIN_START;
      csr_write_data        = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Open window: raw, hole, and a maximal usable region split into 32-bit pieces.
      set_window('0, '0);
      send_region(40'd0, 24'd1, 1'b1, 1'b0);
      send_region(40'd10, 24'd5, 1'b0, 1'b0);
      send_region(40'd15, MAX_PAGES, 1'b1, 1'b1);
      // Overlap, then silence until the map closes.
      send_region(40'd100, 24'd10, 1'b1, 1'b0);
      send_region(40'd105, 24'd1, 1'b0, 1'b0);
      send_region(40'd200, 24'd3, 1'b1, 1'b1);
      // Nothing dumped at all.
      send_region(40'd0, 24'd0, 1'b0, 1'b1);
      // Holes too wide for a chunk, the second at the very top of the page range.
      send_region(40'h2_0000_0000, 24'd1, 1'b1, 1'b1);
      send_region(TOP_PAGE, MAX_PAGES, 1'b1, 1'b1);

      // Bounded window: a region below it, clipping at both ends, words past the end.
      set_window(40'd5, 40'd20);
      send_region(40'd0, 24'd3, 1'b1, 1'b0);
      send_region(40'd4, 24'd10, 1'b1, 1'b0);
      send_region(40'd30, 24'd5, 1'b0, 1'b0);
      send_region(40'd40, 24'd2, 1'b1, 1'b1);
      // Window end never reached.
      send_region(40'd5, 24'd2, 1'b1, 1'b1);

      // Window end below window start: everything clips away.
      set_window(40'd100, 40'd50);
      send_region(40'd0, 24'd200, 1'b1, 1'b1);
      // Both registers at the top.
      set_window(TOP_PAGE, TOP_PAGE);
      send_region(TOP_PAGE - 40'd5, 24'd5, 1'b1, 1'b1);
      // Window just under the top page.
      set_window(TOP_PAGE - 40'd100, '0);
      send_region(TOP_PAGE - 40'(MAX_PAGES), MAX_PAGES, 1'b1, 1'b1);

      // Random maps, mostly well formed; a crowded map every dozen.
      goal = words_sent + RANDOM_WORDS;
      maps = 0;
      while (words_sent < goal) begin
         calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 18);
         if (maps % 12 == 5)  style = MAP_CROWDED;
         else if (pick < 11)  style = MAP_TIDY;
         else if (pick < 14)  style = MAP_OVERLAP;
         else if (pick < 16)  style = MAP_FAR;
         else                 style = MAP_NOISE;
         if (style == MAP_CROWDED) begin
            set_window('0, '0);
         end else if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
               0, 1:    ws = '0;
               2, 3:    ws = START_W'($urandom_range(0, 200));
               4:       ws = rand_page();
               default: ws = TOP_PAGE;
            endcase
            case ($urandom_range(0, 6))
               0, 1:    we = '0;
               2, 3:    we = ws + START_W'($urandom_range(1, 600));
               4:       we = START_W'($urandom_range(0, 100));
               5:       we = TOP_PAGE;
               default: we = rand_page();
            endcase
            set_window(ws, we);
         end
         run_map(style);
         maps++;
      end

      // Drain and report.
      calm = 1'b0;
      settle();
      if (tracker.bad_records == 0 && tracker.pending_records.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
